@@ rtl/cau_pkg.sv @@
`timescale 1ns / 1ps

package cau_pkg;

    // operation codes
    localparam logic [3:0] ACT_ADD  = 4'd0;
    localparam logic [3:0] ACT_SUB  = 4'd1;
    localparam logic [3:0] ACT_MUL  = 4'd2;
    localparam logic [3:0] ACT_DIV  = 4'd3;
    localparam logic [3:0] ACT_CONJ = 4'd4;
    localparam logic [3:0] ACT_SMUL = 4'd5;
    localparam logic [3:0] ACT_SDIV = 4'd6;
    localparam logic [3:0] ACT_SADD = 4'd7;
    localparam logic [3:0] ACT_MOD  = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // operand slots of one request
    localparam int NUM_OPND = 5;
    localparam int OPND_AR  = 0;
    localparam int OPND_AI  = 1;
    localparam int OPND_BR  = 2;
    localparam int OPND_BI  = 3;
    localparam int OPND_S   = 4;

    // depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 4;

    // classification that travels with each request
    typedef struct packed {
        logic [3:0] action;
        logic       dz;
    } t_ctl;

endpackage

@@ rtl/cau_front.sv @@
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; #(
    parameter int W = 32
) (
    input  logic [3:0]                   i_action,
    input  logic [W-1:0]                 i_a_re,
    input  logic [W-1:0]                 i_a_im,
    input  logic [W-1:0]                 i_b_re,
    input  logic [W-1:0]                 i_b_im,
    input  logic [W-1:0]                 i_scalar,
    output t_ctl                         o_ctl,
    output logic [NUM_OPND-1:0][W-1:0]   o_raw,
    output logic [NUM_OPND-1:0][W-1:0]   o_mag
);

    // operand slots
    always_comb begin
        o_raw[OPND_AR] = i_a_re;
        o_raw[OPND_AI] = i_a_im;
        o_raw[OPND_BR] = i_b_re;
        o_raw[OPND_BI] = i_b_im;
        o_raw[OPND_S]  = i_scalar;
    end

    // sign and magnitude form, the most negative value fits as unsigned
    always_comb begin
        for (int k = 0; k < NUM_OPND; k++) begin
            o_mag[k] = o_raw[k][W-1] ? (~o_raw[k] + 1'b1) : o_raw[k];
        end
    end

    // zero divisor detection
    always_comb begin
        o_ctl.action = i_action;
        o_ctl.dz     = ((i_action == ACT_DIV) && (i_b_re == '0) && (i_b_im == '0))
                    || ((i_action == ACT_SDIV) && (i_scalar == '0));
    end

endmodule

@@ rtl/cau_queue.sv @@
`timescale 1ns / 1ps

module cau_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [AW:0]      r_cnt, n_cnt;
    logic             wr_ok;
    logic             rd_ok;

    // flags
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && o_valid;

    // pointer update
    always_comb begin
        n_wp  = wr_ok ? r_wp + 1'b1 : r_wp;
        n_rp  = rd_ok ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/cau_div.sv @@
`timescale 1ns / 1ps

module cau_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [2*W+1:0]   i_num,
    input  logic [2*W-1:0]   i_den,
    input  logic             i_den_neg,
    output logic             o_neg,
    output logic             o_ovf,
    output logic [W-1:0]     o_q
);

    localparam int SW = 2*W + 2;
    localparam int PW = 2*W;
    localparam int NW = 2*W + F;
    localparam int XW = 3*W + F;

    logic [NW-1:0] r_rem [0:W];
    logic [PW-1:0] r_den [0:W];
    logic [W-1:0]  r_q   [0:W];
    logic          r_neg [0:W];
    logic          r_ovf [0:W];

    logic          num_neg;
    logic [SW-1:0] num_abs;
    logic [NW-1:0] num_sh;
    logic          init_ovf;

    // scaled numerator and quotient range check
    always_comb begin
        num_neg  = i_num[SW-1];
        num_abs  = num_neg ? (~i_num + 1'b1) : i_num;
        num_sh   = {num_abs[PW-1:0], {F{1'b0}}};
        init_ovf = {{W{1'b0}}, num_sh} >= {{F{1'b0}}, i_den, {W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= num_sh;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= num_neg ^ i_den_neg;
            r_ovf[0] <= init_ovf;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= W; j++) begin : g_step
        localparam int K = W - j;
        logic [XW-1:0] rem_x;
        logic [XW-1:0] den_x;
        logic [XW-1:0] dif;
        logic          take;

        always_comb begin
            rem_x = {{(XW-NW){1'b0}}, r_rem[j-1]};
            den_x = {{(XW-PW){1'b0}}, r_den[j-1]} << K;
            take  = rem_x >= den_x;
            dif   = rem_x - den_x;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? dif[NW-1:0] : r_rem[j-1];
                r_den[j] <= r_den[j-1];
                r_q[j]   <= r_q[j-1] | (take ? (W'(1) << K) : '0);
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign o_neg = r_neg[W];
    assign o_ovf = r_ovf[W];
    assign o_q   = r_q[W];

endmodule

@@ rtl/cau_back.sv @@
`timescale 1ns / 1ps

module cau_back import cau_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  t_ctl                        i_ctl,
    input  logic [NUM_OPND-1:0][W-1:0]  i_raw,
    input  logic [NUM_OPND-1:0][W-1:0]  i_mag,
    output logic                        o_take,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [W-1:0]                o_re,
    output logic [W-1:0]                o_im,
    output logic [1:0]                  o_status
);

    localparam int PW = 2*W;
    localparam int SW = 2*W + 2;
    localparam int NMUL = 6;

    // saturate a sign and magnitude value, result is {sat, value}
    function automatic logic [W:0] sat_sm(input logic neg, input logic big,
                                          input logic [W-1:0] mag);
        logic [W:0] res;
        if (!neg) begin
            if (big || mag[W-1]) begin
                res = {1'b1, 1'b0, {(W-1){1'b1}}};
            end else begin
                res = {1'b0, mag};
            end
        end else begin
            if (big || (mag[W-1] && (|mag[W-2:0]))) begin
                res = {1'b1, 1'b1, {(W-1){1'b0}}};
            end else begin
                res = {1'b0, ~mag + 1'b1};
            end
        end
        return res;
    endfunction

    // fixed point product sum, magnitude truncated by the fraction
    function automatic logic [W:0] fx_sat(input logic [SW-1:0] x);
        logic          neg;
        logic [SW-1:0] ab;
        logic [SW-1:0] sh;
        neg = x[SW-1];
        ab  = neg ? (~x + 1'b1) : x;
        sh  = ab >> F;
        return sat_sm(neg, |sh[SW-1:W], sh[W-1:0]);
    endfunction

    // narrow sum of two operands
    function automatic logic [W:0] sum_sat(input logic [W:0] x);
        logic       neg;
        logic [W:0] ab;
        neg = x[W];
        ab  = neg ? (~x + 1'b1) : x;
        return sat_sm(neg, ab[W], ab[W-1:0]);
    endfunction

    logic adv;

    // whole back end moves when the result slot frees up
    assign adv    = o_empty || i_pop;
    assign o_take = adv && i_valid;

    // ---------------- stage 1: products and short sums ----------------
    logic [W-1:0] m_x [0:NMUL-1];
    logic [W-1:0] m_y [0:NMUL-1];
    logic         m_s [0:NMUL-1];
    logic [W:0]   s_re;
    logic [W:0]   s_im;
    logic         sg_ar, sg_ai, sg_br, sg_bi, sg_s;

    assign sg_ar = i_raw[OPND_AR][W-1];
    assign sg_ai = i_raw[OPND_AI][W-1];
    assign sg_br = i_raw[OPND_BR][W-1];
    assign sg_bi = i_raw[OPND_BI][W-1];
    assign sg_s  = i_raw[OPND_S][W-1];

    // multiplier operand selection
    always_comb begin
        m_x[0] = i_mag[OPND_AR]; m_y[0] = i_mag[OPND_BR]; m_s[0] = sg_ar ^ sg_br;
        m_x[1] = i_mag[OPND_AI]; m_y[1] = i_mag[OPND_BI]; m_s[1] = sg_ai ^ sg_bi;
        m_x[2] = i_mag[OPND_AR]; m_y[2] = i_mag[OPND_BI]; m_s[2] = sg_ar ^ sg_bi;
        m_x[3] = i_mag[OPND_AI]; m_y[3] = i_mag[OPND_BR]; m_s[3] = sg_ai ^ sg_br;
        m_x[4] = i_mag[OPND_BR]; m_y[4] = i_mag[OPND_BR]; m_s[4] = 1'b0;
        m_x[5] = i_mag[OPND_BI]; m_y[5] = i_mag[OPND_BI]; m_s[5] = 1'b0;
        unique case (i_ctl.action) inside
            ACT_SMUL: begin
                m_y[0] = i_mag[OPND_S]; m_s[0] = sg_ar ^ sg_s;
                m_y[1] = i_mag[OPND_S]; m_s[1] = sg_ai ^ sg_s;
            end
            ACT_MOD: begin
                m_y[0] = i_mag[OPND_AR]; m_s[0] = 1'b0;
                m_y[1] = i_mag[OPND_AI]; m_s[1] = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // add, subtract, conjugate and scalar add
    always_comb begin
        s_re = '0;
        s_im = '0;
        unique case (i_ctl.action) inside
            ACT_ADD: begin
                s_re = {sg_ar, i_raw[OPND_AR]} + {sg_br, i_raw[OPND_BR]};
                s_im = {sg_ai, i_raw[OPND_AI]} + {sg_bi, i_raw[OPND_BI]};
            end
            ACT_SUB: begin
                s_re = {sg_ar, i_raw[OPND_AR]} - {sg_br, i_raw[OPND_BR]};
                s_im = {sg_ai, i_raw[OPND_AI]} - {sg_bi, i_raw[OPND_BI]};
            end
            ACT_CONJ: begin
                s_re = {sg_ar, i_raw[OPND_AR]};
                s_im = ~{sg_ai, i_raw[OPND_AI]} + 1'b1;
            end
            ACT_SADD: begin
                s_re = {sg_ar, i_raw[OPND_AR]} + {sg_s, i_raw[OPND_S]};
                s_im = {sg_ai, i_raw[OPND_AI]};
            end
            default: begin
            end
        endcase
    end

    logic          r1_v;
    t_ctl          r1_ctl;
    logic [PW-1:0] r1_p  [0:NMUL-1];
    logic          r1_ps [0:NMUL-1];
    logic [W:0]    r1_sre;
    logic [W:0]    r1_sim;
    logic [W-1:0]  r1_ar;
    logic [W-1:0]  r1_ai;
    logic [W-1:0]  r1_smag;
    logic          r1_sneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ctl  <= i_ctl;
            r1_sre  <= s_re;
            r1_sim  <= s_im;
            r1_ar   <= i_raw[OPND_AR];
            r1_ai   <= i_raw[OPND_AI];
            r1_smag <= i_mag[OPND_S];
            r1_sneg <= sg_s;
            for (int k = 0; k < NMUL; k++) begin
                r1_p[k]  <= {{W{1'b0}}, m_x[k]} * {{W{1'b0}}, m_y[k]};
                r1_ps[k] <= m_s[k];
            end
        end
    end

    // ---------------- stage 2: product sums ----------------
    logic [SW-1:0] sp [0:NMUL-1];
    logic [SW-1:0] x_re;
    logic [SW-1:0] x_im;
    logic [PW-1:0] x_den;
    logic          x_dneg;

    always_comb begin
        for (int k = 0; k < NMUL; k++) begin
            sp[k] = r1_ps[k] ? (~{2'b00, r1_p[k]} + 1'b1) : {2'b00, r1_p[k]};
        end
    end

    always_comb begin
        x_re   = '0;
        x_im   = '0;
        x_den  = r1_p[4] + r1_p[5];
        x_dneg = 1'b0;
        unique case (r1_ctl.action) inside
            ACT_MUL: begin
                x_re = sp[0] - sp[1];
                x_im = sp[2] + sp[3];
            end
            ACT_DIV: begin
                x_re = sp[0] + sp[1];
                x_im = sp[3] - sp[2];
            end
            ACT_SMUL: begin
                x_re = sp[0];
                x_im = sp[1];
            end
            ACT_SDIV: begin
                x_re   = {{(SW-W){r1_ar[W-1]}}, r1_ar};
                x_im   = {{(SW-W){r1_ai[W-1]}}, r1_ai};
                x_den  = {{W{1'b0}}, r1_smag};
                x_dneg = r1_sneg;
            end
            ACT_MOD: begin
                x_re = {2'b00, r1_p[0]} + {2'b00, r1_p[1]};
            end
            default: begin
            end
        endcase
    end

    logic          r2_v;
    t_ctl          r2_ctl;
    logic [SW-1:0] r2_re;
    logic [SW-1:0] r2_im;
    logic [PW-1:0] r2_den;
    logic          r2_dneg;
    logic [W:0]    r2_sre;
    logic [W:0]    r2_sim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_ctl  <= r1_ctl;
            r2_re   <= x_re;
            r2_im   <= x_im;
            r2_den  <= x_den;
            r2_dneg <= x_dneg;
            r2_sre  <= r1_sre;
            r2_sim  <= r1_sim;
        end
    end

    // ---------------- stage 3: short results, then delay line ----------------
    logic [W:0] side_re;
    logic [W:0] side_im;

    always_comb begin
        side_re = '0;
        side_im = '0;
        unique case (r2_ctl.action) inside
            ACT_ADD, ACT_SUB, ACT_CONJ, ACT_SADD: begin
                side_re = sum_sat(r2_sre);
                side_im = sum_sat(r2_sim);
            end
            ACT_MUL, ACT_SMUL: begin
                side_re = fx_sat(r2_re);
                side_im = fx_sat(r2_im);
            end
            default: begin
            end
        endcase
    end

    logic         r_d_v   [0:W];
    t_ctl         r_d_ctl [0:W];
    logic [W-1:0] r_d_re  [0:W];
    logic [W-1:0] r_d_im  [0:W];
    logic         r_d_sat [0:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) begin
                r_d_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_d_v[0] <= r2_v;
            for (int k = 1; k <= W; k++) begin
                r_d_v[k] <= r_d_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_ctl[0] <= r2_ctl;
            r_d_re[0]  <= side_re[W-1:0];
            r_d_im[0]  <= side_im[W-1:0];
            r_d_sat[0] <= side_re[W] | side_im[W];
            for (int k = 1; k <= W; k++) begin
                r_d_ctl[k] <= r_d_ctl[k-1];
                r_d_re[k]  <= r_d_re[k-1];
                r_d_im[k]  <= r_d_im[k-1];
                r_d_sat[k] <= r_d_sat[k-1];
            end
        end
    end

    // ---------------- quotient pipelines ----------------
    logic         dre_neg, dre_ovf, dim_neg, dim_ovf;
    logic [W-1:0] dre_q;
    logic [W-1:0] dim_q;

    cau_div #(.W(W), .F(F)) u_div_re (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_num     (r2_re),
        .i_den     (r2_den),
        .i_den_neg (r2_dneg),
        .o_neg     (dre_neg),
        .o_ovf     (dre_ovf),
        .o_q       (dre_q)
    );

    cau_div #(.W(W), .F(F)) u_div_im (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_num     (r2_im),
        .i_den     (r2_den),
        .i_den_neg (r2_dneg),
        .o_neg     (dim_neg),
        .o_ovf     (dim_ovf),
        .o_q       (dim_q)
    );

    // ---------------- square root pipeline, one root bit per stage ----------------
    logic [PW-1:0] r_sq_rem  [0:W];
    logic [W-1:0]  r_sq_root [0:W];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0]  <= r2_re[PW-1:0];
            r_sq_root[0] <= '0;
        end
    end

    for (genvar j = 1; j <= W; j++) begin : g_sqrt
        localparam int I = W - j;
        logic [PW:0] trial;
        logic [PW:0] dif;
        logic        take;

        always_comb begin
            trial = ({{(W+1){1'b0}}, r_sq_root[j-1]} << (I + 1))
                  + ((PW+1)'(1) << (2 * I));
            take  = {1'b0, r_sq_rem[j-1]} >= trial;
            dif   = {1'b0, r_sq_rem[j-1]} - trial;
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rem[j]  <= take ? dif[PW-1:0] : r_sq_rem[j-1];
                r_sq_root[j] <= r_sq_root[j-1] | (take ? (W'(1) << I) : '0);
            end
        end
    end

    // ---------------- result selection and output register ----------------
    logic [W:0]   q_re;
    logic [W:0]   q_im;
    logic [W:0]   q_root;
    logic [W-1:0] n_out_re;
    logic [W-1:0] n_out_im;
    logic [1:0]   n_out_st;
    logic         fin_sat;

    always_comb begin
        q_re   = sat_sm(dre_neg, dre_ovf, dre_q);
        q_im   = sat_sm(dim_neg, dim_ovf, dim_q);
        q_root = sat_sm(1'b0, 1'b0, r_sq_root[W]);
        n_out_re = r_d_re[W];
        n_out_im = r_d_im[W];
        fin_sat  = r_d_sat[W];
        unique case (r_d_ctl[W].action) inside
            ACT_DIV, ACT_SDIV: begin
                n_out_re = q_re[W-1:0];
                n_out_im = q_im[W-1:0];
                fin_sat  = q_re[W] | q_im[W];
            end
            ACT_MOD: begin
                n_out_re = q_root[W-1:0];
                n_out_im = '0;
                fin_sat  = q_root[W];
            end
            default: begin
            end
        endcase
        n_out_st = fin_sat ? ST_SAT : ST_OK;
        if (r_d_ctl[W].dz) begin
            n_out_re = '0;
            n_out_im = '0;
            n_out_st = ST_DZ;
        end
    end

    logic         r_out_v;
    logic [W-1:0] r_out_re;
    logic [W-1:0] r_out_im;
    logic [1:0]   r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_d_v[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_re <= n_out_re;
            r_out_im <= n_out_im;
            r_out_st <= n_out_st;
        end
    end

    assign o_empty  = !r_out_v;
    assign o_re     = r_out_re;
    assign o_im     = r_out_im;
    assign o_status = r_out_st;

    // a zero divisor always gives a cleared result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out_st == ST_DZ)) |-> ((r_out_re == '0) && (r_out_im == '0)))
        else $error("zero divisor result not cleared");

    // modulus leaves the imaginary part at zero
    a_mod_im: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_d_v[W] && (r_d_ctl[W].action == ACT_MOD)) |=> (r_out_im == '0))
        else $error("modulus with nonzero imaginary part");

    // a held result freezes the back end
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_pop) |=> ($stable(r_d_v[W]) && $stable(r2_v) && $stable(r1_v)))
        else $error("pipeline moved while result held");

    // nothing is taken from the queue while the back end stands
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_pop) |-> !o_take)
        else $error("request taken during stall");

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps

// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------------
// request   | push in, full out  | i_action, i_a_re, i_a_im, i_b_re, i_b_im, i_scalar
// result    | pop in, empty out  | o_r_re, o_r_im, o_status
//
// one request per cycle sustained while results are popped; a request passes
// the queue, the product and sum stages, then the delay line or the divider
// and square root pipelines, one quotient or root bit per stage, then the
// output register; synchronous active-low reset clears the queue and all
// stage valid flags; while a result is not popped the back end holds; the
// front queue still takes up to four more requests before full rises

module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [3:0]            i_action,
    input  logic [DATA_WIDTH-1:0] i_a_re,
    input  logic [DATA_WIDTH-1:0] i_a_im,
    input  logic [DATA_WIDTH-1:0] i_b_re,
    input  logic [DATA_WIDTH-1:0] i_b_im,
    input  logic [DATA_WIDTH-1:0] i_scalar,
    output logic                  empty,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] o_r_re,
    output logic [DATA_WIDTH-1:0] o_r_im,
    output logic [1:0]            o_status
);

    localparam int W  = DATA_WIDTH;
    localparam int EW = $bits(t_ctl) + 2 * NUM_OPND * W;

    t_ctl                       f_ctl;
    logic [NUM_OPND-1:0][W-1:0] f_raw;
    logic [NUM_OPND-1:0][W-1:0] f_mag;
    t_ctl                       b_ctl;
    logic [NUM_OPND-1:0][W-1:0] b_raw;
    logic [NUM_OPND-1:0][W-1:0] b_mag;
    logic [EW-1:0]              q_wdata;
    logic [EW-1:0]              q_rdata;
    logic                       q_valid;
    logic                       q_take;

    // request classification
    cau_front #(.W(W)) u_front (
        .i_action (i_action),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .i_scalar (i_scalar),
        .o_ctl    (f_ctl),
        .o_raw    (f_raw),
        .o_mag    (f_mag)
    );

    assign q_wdata = {f_ctl, f_raw, f_mag};

    // decoupling queue
    cau_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (q_wdata),
        .o_full  (full),
        .i_rd    (q_take),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {b_ctl, b_raw, b_mag} = q_rdata;

    // arithmetic back end
    cau_back #(.W(W), .F(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_ctl    (b_ctl),
        .i_raw    (b_raw),
        .i_mag    (b_mag),
        .o_take   (q_take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_re     (o_r_re),
        .o_im     (o_r_im),
        .o_status (o_status)
    );

endmodule

@@ test/complex_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int LATENCY = DW + 5;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1330;
    localparam int CALM_ITEMS = 200;

    localparam logic [31:0] QMAX = 32'h7fff_ffff;
    localparam logic [31:0] QMIN = 32'h8000_0000;
    localparam logic [31:0] QONE = 32'h0001_0000;
    localparam logic [3:0] ACT_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] ACT_UNUSED = 4'd15;

    typedef logic signed [159:0] t_wide;

    typedef struct {
        logic [3:0]  action;
        logic [31:0] a_re, a_im, b_re, b_im, scalar;
    } t_request;

    typedef struct {
        logic [31:0] r_re, r_im;
        logic [1:0]  status;
    } t_answer;

    // directed row: request plus an optional hand-written answer
    typedef struct {
        t_request req;
        bit       typed;
        t_answer  ans;
    } t_vector;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push, pop;
    logic full, empty;
    logic [3:0] i_action;
    logic [DW-1:0] i_a_re, i_a_im, i_b_re, i_b_im, i_scalar;
    logic [DW-1:0] o_r_re, o_r_im;
    logic [1:0] o_status;

    t_answer pending_answers[$];
    bit failed = 0;
    bit calm = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_action(i_action), .i_a_re(i_a_re), .i_a_im(i_a_im),
        .i_b_re(i_b_re), .i_b_im(i_b_im), .i_scalar(i_scalar),
        .empty(empty), .pop(pop),
        .o_r_re(o_r_re), .o_r_im(o_r_im), .o_status(o_status)
    );

    // exact value to Q16.16, product scaled back toward zero
    function automatic t_wide drop_frac(t_wide x);
        return (x < 0) ? -((-x) >>> FB) : (x >>> FB);
    endfunction

    // quotient num * 2^FB / den, truncated toward zero
    function automatic t_wide fixed_quot(t_wide num, t_wide den);
        t_wide n, d, q;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n <<< FB) / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic t_wide floor_root(t_wide n);
        t_wide r, c;
        r = 0;
        for (int i = 40; i >= 0; i--) begin
            c = r | (t_wide'(1) <<< i);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp(t_wide x, ref bit sat);
        if (x > t_wide'($signed(QMAX))) begin
            sat = 1;
            return QMAX;
        end
        if (x < t_wide'($signed(QMIN))) begin
            sat = 1;
            return QMIN;
        end
        return x[31:0];
    endfunction

    // predicted answer of the unit for one request
    function automatic t_answer complex_result(t_request rq);
        t_wide ar, ai, br, bi, s, re, im, den;
        bit sat;
        bit dz;
        t_answer an;
        ar = $signed(rq.a_re); ai = $signed(rq.a_im);
        br = $signed(rq.b_re); bi = $signed(rq.b_im);
        s = $signed(rq.scalar);
        re = 0; im = 0; sat = 0; dz = 0;
        case (rq.action)
            ACT_ADD: begin re = ar + br; im = ai + bi; end
            ACT_SUB: begin re = ar - br; im = ai - bi; end
            ACT_MUL: begin
                re = drop_frac(ar * br - ai * bi);
                im = drop_frac(ar * bi + ai * br);
            end
            ACT_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) dz = 1;
                else begin
                    re = fixed_quot(ar * br + ai * bi, den);
                    im = fixed_quot(ai * br - ar * bi, den);
                end
            end
            ACT_CONJ: begin re = ar; im = -ai; end
            ACT_SMUL: begin re = drop_frac(ar * s); im = drop_frac(ai * s); end
            ACT_SDIV: begin
                if (s == 0) dz = 1;
                else begin
                    re = fixed_quot(ar, s);
                    im = fixed_quot(ai, s);
                end
            end
            ACT_SADD: begin re = ar + s; im = ai; end
            ACT_MOD: re = floor_root(ar * ar + ai * ai);
            default: ;
        endcase
        an.r_re = clamp(re, sat);
        an.r_im = clamp(im, sat);
        an.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
        return an;
    endfunction

    // operand with weight on small values and extremes
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 1 << 19) - (1 << 18);
            3: return $urandom_range(0, 1 << 25) - (1 << 24);
            4: begin
                case ($urandom_range(0, 5))
                    0: return 32'd0;
                    1: return 32'd1;
                    2: return 32'hffff_ffff;
                    3: return QMAX;
                    4: return QMIN;
                    default: return QONE;
                endcase
            end
            default: return $urandom_range(0, 1 << 16) - (1 << 15);
        endcase
    endfunction

    // send one request and log its predicted answer when taken
    task automatic send_request(t_request rq);
        push <= 1'b1;
        i_action <= rq.action;
        i_a_re <= rq.a_re; i_a_im <= rq.a_im;
        i_b_re <= rq.b_re; i_b_im <= rq.b_im;
        i_scalar <= rq.scalar;
        do @(posedge i_clk); while (full);
        pending_answers.push_back(complex_result(rq));
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // result side: random pop bursts, steady pop once calm
    initial begin
        pop <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // result check against the oldest pending answer
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && pop && !empty) begin
            if (pending_answers.size() == 0) begin
                $error("result with no request pending: re %h im %h st %0d",
                       o_r_re, o_r_im, o_status);
                failed = 1;
            end else begin
                want = pending_answers.pop_front();
                if (o_r_re !== want.r_re) begin
                    $error("r_re expected %h actual %h", want.r_re, o_r_re);
                    failed = 1;
                end
                if (o_r_im !== want.r_im) begin
                    $error("r_im expected %h actual %h", want.r_im, o_r_im);
                    failed = 1;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    failed = 1;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_vector table_rows[$];
        t_request rq;
        t_answer zero_ans;
        t_answer got;
        zero_ans = '{32'd0, 32'd0, ST_OK};

        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_action <= ACT_ADD;
        i_a_re <= '0; i_a_im <= '0; i_b_re <= '0; i_b_im <= '0; i_scalar <= '0;

        // directed rows
        table_rows.push_back('{'{ACT_ADD, 0, 0, 0, 0, 0}, 1, zero_ans});
        table_rows.push_back('{'{ACT_ADD, QMAX, QMIN, QMAX, QMIN, 0}, 1,
                               '{QMAX, QMIN, ST_SAT}});
        table_rows.push_back('{'{ACT_SUB, QMIN, QMAX, QMAX, QMIN, 0}, 1,
                               '{QMIN, QMAX, ST_SAT}});
        table_rows.push_back('{'{ACT_MUL, QONE, QONE, QONE, QMIN, 0}, 0, zero_ans});
        table_rows.push_back('{'{ACT_MUL, QMAX, QMIN, QMIN, QMAX, 0}, 0, zero_ans});
        table_rows.push_back('{'{ACT_MUL, 32'hffff_ffff, 1, 1, 32'hffff_ffff, 0},
                               0, zero_ans});
        table_rows.push_back('{'{ACT_DIV, QONE, QONE, 0, 0, 0}, 1,
                               '{0, 0, ST_DZ}});
        table_rows.push_back('{'{ACT_DIV, QMAX, QMIN, 1, 0, 0}, 0, zero_ans});
        table_rows.push_back('{'{ACT_DIV, 32'h0003_0000, 32'hfffe_0000, QONE, QMIN,
                                0}, 0, zero_ans});
        table_rows.push_back('{'{ACT_DIV, 1, 32'hffff_ffff, QMIN, QMIN, 0}, 0,
                               zero_ans});
        table_rows.push_back('{'{ACT_CONJ, QMAX, QMIN, 0, 0, 0}, 1,
                               '{QMAX, QMAX, ST_SAT}});
        table_rows.push_back('{'{ACT_CONJ, QMIN, 32'd5, 0, 0, 0}, 1,
                               '{QMIN, 32'hffff_fffb, ST_OK}});
        table_rows.push_back('{'{ACT_SMUL, QMIN, QMAX, 0, 0, QMIN}, 0, zero_ans});
        table_rows.push_back('{'{ACT_SMUL, 32'hffff_ffff, 1, 0, 0, 32'h0000_ffff},
                               0, zero_ans});
        table_rows.push_back('{'{ACT_SDIV, QONE, QONE, 0, 0, 0}, 1,
                               '{0, 0, ST_DZ}});
        table_rows.push_back('{'{ACT_SDIV, QMIN, QMAX, 0, 0, 32'hffff_ffff}, 0,
                               zero_ans});
        table_rows.push_back('{'{ACT_SDIV, 32'd7, 32'hffff_fff9, 0, 0, QMAX}, 0,
                               zero_ans});
        table_rows.push_back('{'{ACT_SADD, QMAX, QMIN, 0, 0, 1}, 1,
                               '{QMAX, QMIN, ST_SAT}});
        table_rows.push_back('{'{ACT_SADD, QMIN, 3, 0, 0, QMIN}, 1,
                               '{QMIN, 3, ST_SAT}});
        table_rows.push_back('{'{ACT_MOD, QMIN, QMIN, 0, 0, 0}, 1,
                               '{QMAX, 0, ST_SAT}});
        table_rows.push_back('{'{ACT_MOD, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0}, 1,
                               '{32'h0005_0000, 0, ST_OK}});
        table_rows.push_back('{'{ACT_MOD, 0, 0, 0, 0, 0}, 1, zero_ans});
        table_rows.push_back('{'{ACT_FIRST_UNUSED, QMAX, QMIN, QMAX, QMIN, QMAX}, 1,
                               zero_ans});
        table_rows.push_back('{'{ACT_UNUSED, 1, 1, 1, 1, 1}, 1, zero_ans});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: typed answers are checked against the predictor too
        foreach (table_rows[k]) begin
            if (table_rows[k].typed) begin
                got = complex_result(table_rows[k].req);
                if ((got.r_re !== table_rows[k].ans.r_re)
                    || (got.r_im !== table_rows[k].ans.r_im)
                    || (got.status !== table_rows[k].ans.status)) begin
                    $error("row %0d: typed answer r_re %h r_im %h st %0d, predicted %h %h %0d",
                           k, table_rows[k].ans.r_re, table_rows[k].ans.r_im,
                           table_rows[k].ans.status, got.r_re, got.r_im, got.status);
                    failed = 1;
                end
            end
            send_request(table_rows[k].req);
            sender_gap();
        end

        // hold off until the unit has drained
        push <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);

        // random part, idling stops for the last stretch
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1;
            rq.action = ($urandom_range(0, 19) > 17)
                      ? 4'($urandom_range(ACT_FIRST_UNUSED, ACT_UNUSED))
                      : 4'($urandom_range(ACT_ADD, ACT_MOD));
            rq.a_re = pick_operand(); rq.a_im = pick_operand();
            rq.b_re = pick_operand(); rq.b_im = pick_operand();
            rq.scalar = pick_operand();
            if ($urandom_range(0, 9) == 0) begin
                rq.b_re = 0; rq.b_im = 0; rq.scalar = 0;
            end
            send_request(rq);
            sender_gap();
        end
        push <= 1'b0;

        // drain and settle
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (!failed) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
